FILE: rtl/core/lsm_pkg.sv
// shared types and constants of the latency statistics monitor
package lsm_pkg;

    localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;
    localparam logic [31:0] MEAN_EXACT_LIMIT = 32'h0000_FFFF;
    localparam logic [31:0] MS_PER_SECOND    = 32'd1000;
    localparam logic [31:0] MIN_RESET        = 32'hFFFF_FFFF;

    // busy load: product at or above this gives a load above the cap
    localparam logic [31:0] BUSY_CAP_PROD    = 32'd1010000;
    // reciprocal of 10000 scaled by 2^34, exact for products below 2^20
    localparam logic [31:0] BUSY_RECIP       = 32'd1717987;
    localparam int          BUSY_SHIFT       = 34;
    localparam logic [6:0]  BUSY_CAP         = 7'd100;

    localparam logic [31:0] LAT_FREE         = 32'd1000;
    localparam logic [31:0] LAT_ZERO_SPAN    = 32'd10100;
    localparam logic [31:0] RATE_FULL        = 32'd1000;
    localparam logic [6:0]  LOAD_THRESHOLD   = 7'd80;
    localparam logic [6:0]  SCORE_FULL       = 7'd100;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

endpackage

FILE: rtl/core/lsm_mul.sv
// shared registered 32 x 32 multiplier with full 64-bit product
module lsm_mul
    import lsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mul_req    i_req,
    output logic [63:0] o_prod,
    output logic        o_done
);

    logic [63:0] r_prod;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
        if (i_req.start) begin
            r_prod <= {32'd0, i_req.a} * {32'd0, i_req.b};
        end
    end

    assign o_prod = r_prod;
    assign o_done = r_done;

endmodule

FILE: rtl/core/lsm_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
module lsm_div
    import lsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic [31:0] o_quot,
    output logic        o_done
);

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [4:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_shift;
    logic [32:0] n_diff;

    always_comb begin
        n_shift = {r_rem, r_quo[31]};
        n_diff  = n_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (!n_diff[32]) begin
                r_rem <= n_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= n_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

FILE: rtl/core/latency_stats_monitor_unit.sv
// latency statistics monitor top level: sequencer, statistics and result register
//
// s_axis carries one request per completed operation: its latency in
// microseconds and the current millisecond time. For every request one
// result leaves on m_axis: count, min, max, mean, operations per second,
// busy percent and health score.
// a request is worked through the sequencer steps up to a valid result, with the
// two divisions (mean, rate) on the shared divider and passes through the shared
// multiplier; a skipped mean or rate division (first item, weighted mean, zero
// elapsed time) also skips the multiplier pass before it, a zero busy load skips
// both busy passes and a capped one skips the reciprocal pass.
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register while the next request is already taken.
// if the receiver stalls, the sequencer holds its last step until the
// output register is free.
// the start time is written on the cfg channel, always ready; the user
// writes it only while idle, which the block itself does not enforce.
// reset clears all statistics (min to all ones) and the start time.
module latency_stats_monitor_unit
    import lsm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data,    // start_time
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // latency_us, now_ms
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // op_count, min_latency, max_latency, mean_latency, ops_per_second,
    // busy_percent, health_score
    output logic [175:0] m_axis_tdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_MEAN_MUL,
        S_MEAN_DIV,
        S_RATE,
        S_RATE_MUL,
        S_RATE_DIV,
        S_BUSY,
        S_BUSY_MUL,
        S_BUSY_RCP,
        S_HEALTH1,
        S_HEALTH2
    } t_state;

    t_state       r_state;
    logic [31:0]  r_start;
    logic [31:0]  r_lat;
    logic [31:0]  r_now;
    logic [31:0]  r_count;
    logic [31:0]  r_min;
    logic [31:0]  r_max;
    logic [31:0]  r_mean;
    logic [31:0]  r_rate;
    logic [6:0]   r_busy;
    logic [6:0]   r_lat_s;
    logic [6:0]   r_rate_s;
    logic [6:0]   r_load_s;
    logic         r_m_tvalid;
    logic [175:0] r_m_tdata;
    t_mul_req     r_mul_req;
    t_div_req     r_div_req;

    logic [63:0]  mul_prod;
    logic         mul_done;
    logic [31:0]  div_quot;
    logic         div_done;

    logic [31:0]  n_count;
    logic [31:0]  n_wavg;
    logic [31:0]  n_elapsed;
    logic [31:0]  n_lat_d;
    logic [26:0]  n_lat_prod;
    logic [17:0]  n_rate_prod;
    logic [8:0]   n_total;
    logic [16:0]  n_health_prod;
    logic [6:0]   n_health;
    logic         n_out_free;

    lsm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    lsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    always_comb begin
        n_count       = (r_count != COUNT_MAX) ? r_count + 32'd1 : r_count;
        n_wavg        = {r_mean[27:0], 4'd0} - r_mean + r_lat;
        n_elapsed     = r_now - r_start;
        n_lat_d       = r_mean - LAT_FREE;
        n_lat_prod    = 27'(n_lat_d[13:0]) * 27'd5243;
        n_rate_prod   = 18'(r_rate[9:0]) * 18'd205;
        n_total       = 9'(r_lat_s) + 9'(r_rate_s) + 9'(r_load_s);
        n_health_prod = 17'(n_total) * 17'd171;
        n_health      = n_health_prod[15:9];
        n_out_free    = !r_m_tvalid || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= '0;
            r_count    <= '0;
            r_min      <= MIN_RESET;
            r_max      <= '0;
            r_mean     <= '0;
            r_rate     <= '0;
            r_busy     <= '0;
            r_m_tvalid <= 1'b0;
            r_mul_req  <= '0;
            r_div_req  <= '0;
        end else begin
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            if (r_m_tvalid && m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_lat   <= s_axis_tdata[31:0];
                        r_now   <= s_axis_tdata[63:32];
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_count <= n_count;
                    if (r_lat < r_min) begin
                        r_min <= r_lat;
                    end
                    if (r_lat > r_max) begin
                        r_max <= r_lat;
                    end
                    if (n_count == 32'd1) begin
                        r_mean  <= r_lat;
                        r_state <= S_RATE;
                    end else if (n_count > MEAN_EXACT_LIMIT) begin
                        r_mean  <= {4'd0, n_wavg[31:4]};
                        r_state <= S_RATE;
                    end else begin
                        r_mul_req <= '{start: 1'b1, a: r_mean, b: r_count};
                        r_state   <= S_MEAN_MUL;
                    end
                end
                S_MEAN_MUL: begin
                    if (mul_done) begin
                        r_div_req <= '{start: 1'b1, dividend: mul_prod[31:0] + r_lat,
                                       divisor: r_count};
                        r_state   <= S_MEAN_DIV;
                    end
                end
                S_MEAN_DIV: begin
                    if (div_done) begin
                        r_mean  <= div_quot;
                        r_state <= S_RATE;
                    end
                end
                S_RATE: begin
                    if (n_elapsed != 32'd0) begin
                        r_mul_req <= '{start: 1'b1, a: r_count, b: MS_PER_SECOND};
                        r_state   <= S_RATE_MUL;
                    end else begin
                        r_state <= S_BUSY;
                    end
                end
                S_RATE_MUL: begin
                    if (mul_done) begin
                        r_div_req <= '{start: 1'b1, dividend: mul_prod[31:0],
                                       divisor: n_elapsed};
                        r_state   <= S_RATE_DIV;
                    end
                end
                S_RATE_DIV: begin
                    if (div_done) begin
                        r_rate  <= div_quot;
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (r_mean != 32'd0 && r_rate != 32'd0) begin
                        r_mul_req <= '{start: 1'b1, a: r_mean, b: r_rate};
                        r_state   <= S_BUSY_MUL;
                    end else begin
                        r_state <= S_HEALTH1;
                    end
                end
                S_BUSY_MUL: begin
                    if (mul_done) begin
                        if (mul_prod[31:0] >= BUSY_CAP_PROD) begin
                            r_busy  <= BUSY_CAP;
                            r_state <= S_HEALTH1;
                        end else begin
                            r_mul_req <= '{start: 1'b1, a: mul_prod[31:0], b: BUSY_RECIP};
                            r_state   <= S_BUSY_RCP;
                        end
                    end
                end
                S_BUSY_RCP: begin
                    if (mul_done) begin
                        r_busy  <= mul_prod[BUSY_SHIFT+6:BUSY_SHIFT];
                        r_state <= S_HEALTH1;
                    end
                end
                S_HEALTH1: begin
                    if (r_mean <= LAT_FREE) begin
                        r_lat_s <= SCORE_FULL;
                    end else if (n_lat_d >= LAT_ZERO_SPAN) begin
                        r_lat_s <= '0;
                    end else begin
                        r_lat_s <= SCORE_FULL - n_lat_prod[25:19];
                    end
                    if (r_rate > RATE_FULL) begin
                        r_rate_s <= SCORE_FULL;
                    end else begin
                        r_rate_s <= n_rate_prod[17:11];
                    end
                    if (r_busy < LOAD_THRESHOLD) begin
                        r_load_s <= SCORE_FULL;
                    end else begin
                        r_load_s <= SCORE_FULL - r_busy;
                    end
                    r_state <= S_HEALTH2;
                end
                S_HEALTH2: begin
                    if (n_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {2'd0, n_health, r_busy, r_rate, r_mean,
                                       r_max, r_min, r_count};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:32] <= m_axis_tdata[95:64]))
        else $error("min latency above max latency");

    a_scores_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[166:160] <= BUSY_CAP
                           && m_axis_tdata[173:167] <= SCORE_FULL))
        else $error("busy or health above 100");

    a_count_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_count != 32'd0))
        else $error("count zero after an update");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_req.start |-> (r_div_req.divisor != 32'd0))
        else $error("division by zero started");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");

endmodule

FILE: sim/latency_stats_monitor_unit_tb.sv
// self-checking testbench of the latency statistics monitor with its own statistics predictor
`timescale 1ns / 1ps

module latency_stats_monitor_unit_tb
    import lsm_pkg::*;
();

    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned STALL_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 150;
    localparam int unsigned HOLD_CYCLES   = 2500;
    localparam int unsigned PHASE_ITEMS   = 220;
    localparam int unsigned HOLD_ITEMS    = 12;
    localparam logic [31:0] BUSY_DIVISOR  = 32'd10000;
    localparam logic [31:0] LAT_STEP      = 32'd100;
    localparam logic [31:0] WEIGHT_OLD    = 32'd15;
    localparam logic [31:0] WEIGHT_SUM    = 32'd16;

    // result fields from the top bit down, matching the m_axis_tdata layout
    typedef struct packed {
        logic [1:0]  pad;
        logic [6:0]  health_score;
        logic [6:0]  busy_percent;
        logic [31:0] ops_per_second;
        logic [31:0] mean_latency;
        logic [31:0] max_latency;
        logic [31:0] min_latency;
        logic [31:0] op_count;
    } t_stats;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [175:0] m_axis_tdata;

    // predicted block state
    logic [31:0] st_start;
    logic [31:0] st_count;
    logic [31:0] st_min;
    logic [31:0] st_max;
    logic [31:0] st_mean;
    logic [31:0] st_rate;
    logic [6:0]  st_busy;

    t_stats      pending_stats[$];
    t_stats      due_result;
    t_stats      seen_result;

    int          fail_count;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned cfg_writes;
    int unsigned quiet_cycles;

    bit          source_idling;
    bit          sink_idling;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned sink_gap_left;

    latency_stats_monitor_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [6:0] health_from(input logic [31:0] mean, input logic [31:0] rate,
                                               input logic [6:0] busy);
        logic [31:0] lat_s;
        logic [31:0] rate_s;
        logic [31:0] load_s;
        logic [31:0] total;
        lat_s = 32'(SCORE_FULL);
        if (mean > LAT_FREE) begin
            lat_s = 32'(SCORE_FULL) - ((mean - LAT_FREE) / LAT_STEP);
            if (lat_s > 32'(SCORE_FULL)) begin
                lat_s = 32'd0;
            end
        end
        rate_s = (rate > RATE_FULL) ? 32'(SCORE_FULL) : rate / 32'd10;
        load_s = (busy < LOAD_THRESHOLD) ? 32'(SCORE_FULL) : 32'(SCORE_FULL) - 32'(busy);
        total = (lat_s + rate_s + load_s) / 32'd3;
        return (total > 32'(SCORE_FULL)) ? SCORE_FULL : total[6:0];
    endfunction

    function automatic t_stats update_stats(input logic [31:0] lat, input logic [31:0] now);
        logic [31:0] acc;
        logic [31:0] elapsed;
        logic [31:0] load;
        t_stats      r;
        if (st_count != COUNT_MAX) begin
            st_count = st_count + 32'd1;
        end
        if (lat < st_min) begin
            st_min = lat;
        end
        if (lat > st_max) begin
            st_max = lat;
        end
        if (st_count == 32'd1) begin
            st_mean = lat;
        end else if (st_count > MEAN_EXACT_LIMIT) begin
            acc = st_mean * WEIGHT_OLD + lat;
            st_mean = acc / WEIGHT_SUM;
        end else begin
            acc = st_mean * (st_count - 32'd1) + lat;
            st_mean = acc / st_count;
        end
        elapsed = now - st_start;
        if (elapsed != 32'd0) begin
            acc = st_count * MS_PER_SECOND;
            st_rate = acc / elapsed;
        end
        if (st_mean != 32'd0 && st_rate != 32'd0) begin
            acc = st_mean * st_rate;
            load = acc / BUSY_DIVISOR;
            st_busy = (load > 32'(BUSY_CAP)) ? BUSY_CAP : load[6:0];
        end
        r.pad            = 2'b00;
        r.op_count       = st_count;
        r.min_latency    = st_min;
        r.max_latency    = st_max;
        r.mean_latency   = st_mean;
        r.ops_per_second = st_rate;
        r.busy_percent   = st_busy;
        r.health_score   = health_from(st_mean, st_rate, st_busy);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result = m_axis_tdata;
            if (pending_stats.size() == 0) begin
                $error("result with no request pending: op_count %0d", seen_result.op_count);
                fail_count++;
            end else begin
                due_result = pending_stats.pop_front();
                check_field("op_count", due_result.op_count, seen_result.op_count);
                check_field("min_latency", due_result.min_latency, seen_result.min_latency);
                check_field("max_latency", due_result.max_latency, seen_result.max_latency);
                check_field("mean_latency", due_result.mean_latency, seen_result.mean_latency);
                check_field("ops_per_second", due_result.ops_per_second,
                            seen_result.ops_per_second);
                check_field("busy_percent", 32'(due_result.busy_percent),
                            32'(seen_result.busy_percent));
                check_field("health_score", 32'(due_result.health_score),
                            32'(seen_result.health_score));
                results_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_gap_left != 0) begin
            sink_gap_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (sink_idling && $urandom_range(0, 7) == 0) begin
                sink_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                            : $urandom_range(1, 4);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL latency_stats_monitor_unit");
                $finish;
            end
        end
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_item(input logic [31:0] lat, input logic [31:0] now);
        int unsigned gap;
        int unsigned pick;
        s_axis_tdata  = {now, lat};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_stats.push_back(update_stats(lat, now));
        items_sent++;
        @(negedge i_clk);
        gap = 0;
        if (source_idling) begin
            pick = $urandom_range(0, 9);
            if (pick >= 9) begin
                gap = $urandom_range(20, 200);
            end else if (pick >= 6) begin
                gap = $urandom_range(1, 5);
            end
        end
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_start_time(input logic [31:0] value);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        st_start = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_sink_idling(input bit on);
        @(posedge i_clk);
        sink_idling = on;
        @(negedge i_clk);
    endtask

    task automatic test_first_items();
        logic [31:0] wrap_lat;
        // start time still at its reset value
        send_item(32'd500, 32'd0);
        send_item(32'd1500, 32'd2);
        send_item(32'd300, 32'd3);
        send_item(32'd20000, 32'd1000);
        send_item(32'd1000000, 32'd1001);
        send_item(32'd12, 32'hFFFF_FFF0);
        wait_drained();
        write_start_time(32'd5000);
        send_item(32'd800, 32'd5000);
        send_item(32'd700, 32'd4000);
        send_item(32'd2500, 32'd5001);
        send_item(32'd900, 32'd5100);
        // latency chosen so the running sum wraps to zero
        wrap_lat = 32'd0 - st_mean * st_count;
        send_item(wrap_lat, 32'd5200);
        send_item(32'd1000, 32'd5201);
        wait_drained();
    endtask

    task automatic test_random_phase(input logic [31:0] start_value);
        logic [31:0] lat;
        logic [31:0] now;
        logic [31:0] t;
        int unsigned step_max;
        int unsigned kind;
        int unsigned pick;
        wait_drained();
        write_start_time(start_value);
        t = $urandom_range(0, 20);
        step_max = 10;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) begin
                pick = $urandom_range(0, 2);
                step_max = (pick == 0) ? 2 : (pick == 1) ? 10 : 60;
            end
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                now = st_start;
            end else if (kind == 1) begin
                now = $urandom();
            end else begin
                t = t + $urandom_range(0, step_max);
                now = st_start + t;
            end
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                lat = $urandom();
            end else if (pick <= 4) begin
                lat = $urandom_range(0, 100);
            end else if (pick <= 20) begin
                lat = $urandom_range(100, 2000);
            end else begin
                lat = $urandom_range(1000, 15000);
            end
            send_item(lat, now);
        end
        wait_drained();
    endtask

    // result side blocked for a long stretch while requests keep coming
    task automatic test_output_hold();
        bit saved;
        saved = source_idling;
        source_idling = 1'b0;
        @(posedge i_clk);
        hold_request = 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < HOLD_ITEMS; i++) begin
            send_item($urandom_range(200, 3000), st_start + 32'(100 + i));
        end
        source_idling = saved;
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_item(32'd0, st_start + 32'd7);
        send_item(32'hFFFF_FFFF, st_start + 32'd8);
        send_item(32'd100, 32'd0);
        send_item(32'd100, 32'hFFFF_FFFF);
        wait_drained();
        write_start_time(32'hFFFF_FFFF);
        send_item(32'd5, 32'hFFFF_FFFF);
        send_item(32'd6, 32'd0);
        wait_drained();
        write_start_time(32'd0);
        send_item(32'd7, 32'd0);
        send_item(32'd8, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 32'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 64'd0;
        m_axis_tready = 1'b0;
        fail_count      = 0;
        items_sent      = 0;
        results_checked = 0;
        cfg_writes      = 0;
        quiet_cycles    = 0;
        source_idling   = 1'b1;
        sink_idling     = 1'b1;
        hold_request    = 1'b0;
        hold_left       = 0;
        sink_gap_left   = 0;
        st_start = 32'd0;
        st_count = 32'd0;
        st_min   = MIN_RESET;
        st_max   = 32'd0;
        st_mean  = 32'd0;
        st_rate  = 32'd0;
        st_busy  = 7'd0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_first_items();
        test_random_phase(32'd0);
        source_idling = 1'b0;
        set_sink_idling(1'b0);
        test_random_phase(32'hFFFF_FFFF);
        source_idling = 1'b1;
        set_sink_idling(1'b1);
        test_random_phase(32'h8000_0000);
        test_random_phase($urandom());
        test_output_hold();
        test_random_phase(32'hFFFF_FF00 + 32'($urandom_range(0, 255)));
        test_random_phase(32'd1);
        test_field_extremes();

        wait_drained();
        $display("covered %0d requests and %0d results under %0d start-time settings,",
                 items_sent, results_checked, cfg_writes);
        $display("with idle gaps, a long output hold and wrapped elapsed times");
        if (fail_count == 0) begin
            $display("PASS latency_stats_monitor_unit");
        end else begin
            $display("FAIL latency_stats_monitor_unit");
        end
        $finish;
    end

endmodule
